// File: rtl/mono_page_frame_buffer_engine_top_defines.svh
// Assertion helpers for the frame buffer engine checkers.
`ifndef MONO_PAGE_FRAME_BUFFER_ENGINE_TOP_DEFINES_SVH
`define MONO_PAGE_FRAME_BUFFER_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MPFB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MPFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mpfb_pkg.sv
package mpfb_pkg;

  // Default panel geometry
  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;
  localparam int GLYPH_WIDTH_DEF  = 6;

  // Fixed field widths
  localparam int PIXEL_WORD_W = 64;
  localparam int WORD_IDX_W   = 7;
  localparam int GLYPH_BITS   = 40;
  localparam int GLYPH_COLS   = 5;
  // Byte counter inside one character (glyph width is at most 8)
  localparam int CHAR_CNT_W   = 3;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef enum logic [3:0] {
    OP_PIX_CLR = 4'd0,
    OP_PIX_SET = 4'd1,
    OP_PIX_INV = 4'd2,
    OP_FILL    = 4'd3,
    OP_CLEAR   = 4'd4,
    OP_CURSOR  = 4'd5,
    OP_CHAR    = 4'd6,
    OP_RAW     = 4'd7,
    OP_PAGE    = 4'd8,
    OP_TOGGLE  = 4'd9
  } op_e;

  // Store control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic fill_en;
    logic fill_ones;
  } mem_ctl_t;

  // Glyph column byte; columns past the fifth read as zero
  function automatic logic [7:0] glyph_byte(input logic [GLYPH_BITS-1:0] g,
                                            input logic [CHAR_CNT_W-1:0] i);
    case (i)
      3'd0:    return g[7:0];
      3'd1:    return g[15:8];
      3'd2:    return g[23:16];
      3'd3:    return g[31:24];
      3'd4:    return g[39:32];
      default: return BYTE_ZERO;
    endcase
  endfunction

endpackage

// File: rtl/mpfb_ram.sv
module mpfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/mpfb_store.sv
// Frame store: word RAM plus per-word valid bits and a background bit.
// A word that is not valid reads as the background (all zero after reset,
// or whatever the last fill/clear set), so fill and clear need no RAM pass.
module mpfb_store import mpfb_pkg::*; #(
  parameter int NUM_WORDS = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mem_ctl_t                     ctl_i,
  input  logic [$clog2(NUM_WORDS)-1:0] rd_addr_i,
  input  logic [$clog2(NUM_WORDS)-1:0] wr_addr_i,
  input  logic [PIXEL_WORD_W-1:0]      wr_data_i,
  output logic [PIXEL_WORD_W-1:0]      rd_data_o
);

  logic                    valid_q [NUM_WORDS];
  logic                    bg_ones_q;
  logic                    rd_valid_q;
  logic [PIXEL_WORD_W-1:0] ram_rdata;

  mpfb_ram #(
    .WIDTH(PIXEL_WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ctl_i.wr_en),
    .wr_addr_i(wr_addr_i),
    .wr_data_i(wr_data_i),
    .rd_en_i  (ctl_i.rd_en),
    .rd_addr_i(rd_addr_i),
    .rd_data_o(ram_rdata)
  );

  // Valid bits: a fill or clear drops them all and wins over a same-cycle write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        valid_q[i] <= 1'b0;
      end
      bg_ones_q  <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (ctl_i.fill_en) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          valid_q[i] <= 1'b0;
        end
        bg_ones_q <= ctl_i.fill_ones;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? ram_rdata : {PIXEL_WORD_W{bg_ones_q}};

endmodule

// File: rtl/mpfb_ctrl.sv
// Command sequencer: decodes a word, runs byte read-modify-write passes on
// the store, streams page reads and registers the result word.
module mpfb_ctrl import mpfb_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
  localparam int NUM_WORDS   = PANEL_WIDTH * (PANEL_HEIGHT / 8) / 8,
  localparam int WAW         = $clog2(NUM_WORDS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [3:0]              opcode_i,
  input  logic [6:0]              x_coord_i,
  input  logic [5:0]              y_coord_i,
  input  logic [2:0]              text_row_i,
  input  logic [4:0]              text_col_i,
  input  logic [GLYPH_BITS-1:0]   glyph_columns_i,
  input  logic                    invert_char_i,
  input  logic                    step_back_i,
  input  logic [7:0]              raw_byte_i,
  input  logic [2:0]              page_index_i,
  output mem_ctl_t                mem_ctl_o,
  output logic [WAW-1:0]          rd_addr_o,
  output logic [WAW-1:0]          wr_addr_o,
  output logic [PIXEL_WORD_W-1:0] wr_data_o,
  input  logic [PIXEL_WORD_W-1:0] rd_data_i,
  output logic                    result_valid_o,
  output logic [PIXEL_WORD_W-1:0] pixel_word_o,
  output logic [WORD_IDX_W-1:0]   word_index_o,
  output logic                    last_word_o,
  output logic                    display_on_o
);

  localparam int STORE_BYTES = PANEL_WIDTH * (PANEL_HEIGHT / 8);
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = AW + 2;
  localparam int PAGE_COUNT  = PANEL_HEIGHT / 8;
  localparam int WPP         = PANEL_WIDTH / 8;
  localparam int KW          = $clog2(WPP);
  localparam int BACK_K      = (2 * GLYPH_WIDTH) % STORE_BYTES;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_WR   = 4'b0100,
    ST_PAGE = 4'b1000
  } state_e;

  // Reduce a value below four store sizes into the store
  function automatic logic [AW-1:0] wrap_addr(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (r >= CW'(STORE_BYTES)) begin
        r = r - CW'(STORE_BYTES);
      end
    end
    return r[AW-1:0];
  endfunction

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [AW-1:0]           addr_q, addr_d;
  logic [AW-1:0]           cursor_q, cursor_d;
  logic [7:0]              mask_q, mask_d;
  logic [GLYPH_BITS-1:0]   glyph_q, glyph_d;
  logic                    inv_q, inv_d;
  logic                    back_q, back_d;
  logic [7:0]              raw_q, raw_d;
  logic [CHAR_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    disp_q, disp_d;
  logic [WAW-1:0]          page_base_q, page_base_d;
  logic [KW-1:0]           k_q, k_d;
  logic                    pend_q, pend_d;
  logic [WAW-1:0]          pend_idx_q, pend_idx_d;
  logic                    pend_last_q, pend_last_d;
  logic                    out_valid_q, out_valid_d;
  logic [PIXEL_WORD_W-1:0] pixel_word_q, pixel_word_d;
  logic [WORD_IDX_W-1:0]   word_index_q, word_index_d;
  logic                    last_q, last_d;
  logic                    disp_out_q, disp_out_d;

  logic                    accept;
  logic                    done_wr;
  logic                    pix_op;
  logic [AW-1:0]           sel_addr;
  logic [2:0]              lane;
  logic [7:0]              old_byte;
  logic [7:0]              new_byte;
  logic [7:0]              char_byte;
  logic [AW-1:0]           cur_inc;
  logic [AW-1:0]           cur_back;
  logic [CW-1:0]           pix_sum;
  logic [CW-1:0]           cur_sum;
  logic [4:0]              page_wrap;
  logic [WAW-1:0]          page_rd_addr;
  logic [WAW+WORD_IDX_W-1:0] idx_ext;

  // Handshake: free in idle once the page pipe is empty, or on the last write
  assign pix_op  = op_q inside {OP_PIX_CLR, OP_PIX_SET, OP_PIX_INV};
  assign done_wr = (state_q == ST_WR) &&
                   ((op_q != OP_CHAR) || (cnt_q == CHAR_CNT_W'(GLYPH_WIDTH - 1)));
  assign busy_o  = !(((state_q == ST_IDLE) && !pend_q) || done_wr);
  assign accept  = start_i && !busy_o;

  // Byte address of the current read-modify-write
  assign sel_addr = pix_op ? addr_q : cursor_q;
  assign lane     = sel_addr[2:0];
  assign old_byte = rd_data_i[{lane, 3'b000} +: 8];

  assign char_byte = ((cnt_q == CHAR_CNT_W'(GLYPH_WIDTH - 1)) ? BYTE_ZERO
                      : glyph_byte(glyph_q, cnt_q)) ^ (inv_q ? BYTE_ONES : BYTE_ZERO);

  always_comb begin
    case (op_q)
      OP_PIX_CLR: new_byte = old_byte & ~mask_q;
      OP_PIX_SET: new_byte = old_byte | mask_q;
      OP_PIX_INV: new_byte = old_byte ^ mask_q;
      OP_RAW:     new_byte = raw_q;
      OP_CHAR:    new_byte = char_byte;
      default:    new_byte = old_byte;
    endcase
  end

  // Merge the new byte into the word just read
  always_comb begin
    wr_data_o = rd_data_i;
    for (int j = 0; j < 8; j++) begin
      if (lane == 3'(j)) begin
        wr_data_o[8*j +: 8] = new_byte;
      end
    end
  end

  // Address arithmetic
  assign pix_sum  = CW'(x_coord_i) + CW'(y_coord_i[5:3]) * CW'(PANEL_WIDTH);
  assign cur_sum  = CW'(text_row_i) * CW'(PANEL_WIDTH) + CW'(text_col_i) * CW'(GLYPH_WIDTH);
  assign cur_inc  = wrap_addr(CW'(cursor_q) + CW'(1));
  assign cur_back = wrap_addr(CW'(cur_inc) + CW'(STORE_BYTES - BACK_K));

  always_comb begin
    page_wrap = {2'b00, page_index_i};
    if (page_wrap >= 5'(PAGE_COUNT)) begin
      page_wrap = page_wrap - 5'(PAGE_COUNT);
    end
  end

  assign page_rd_addr = page_base_q + WAW'(k_q);
  assign idx_ext      = {{WORD_IDX_W{1'b0}}, pend_idx_q};

  // Store port
  assign mem_ctl_o.rd_en     = (state_q == ST_RD) || (state_q == ST_PAGE);
  assign mem_ctl_o.wr_en     = (state_q == ST_WR);
  assign mem_ctl_o.fill_en   = accept && ((opcode_i == OP_FILL) || (opcode_i == OP_CLEAR));
  assign mem_ctl_o.fill_ones = (opcode_i == OP_FILL);
  assign rd_addr_o = (state_q == ST_PAGE) ? page_rd_addr : sel_addr[AW-1:3];
  assign wr_addr_o = sel_addr[AW-1:3];

  // Sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    addr_d       = addr_q;
    cursor_d     = cursor_q;
    mask_d       = mask_q;
    glyph_d      = glyph_q;
    inv_d        = inv_q;
    back_d       = back_q;
    raw_d        = raw_q;
    cnt_d        = cnt_q;
    disp_d       = disp_q;
    page_base_d  = page_base_q;
    k_d          = k_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = 1'b0;
    pixel_word_d = pixel_word_q;
    word_index_d = word_index_q;
    last_d       = last_q;
    disp_out_d   = disp_out_q;

    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (op_q == OP_RAW) begin
          cursor_d = cur_inc;
        end else if (op_q == OP_CHAR) begin
          cursor_d = cur_inc;
          cnt_d    = cnt_q + CHAR_CNT_W'(1);
          if (done_wr && back_q) begin
            cursor_d = cur_back;
          end
        end
        state_d = done_wr ? ST_IDLE : ST_RD;
      end
      ST_PAGE: begin
        pend_d      = 1'b1;
        pend_idx_d  = page_rd_addr;
        pend_last_d = (k_q == KW'(WPP - 1));
        k_d         = k_q + KW'(1);
        if (k_q == KW'(WPP - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Page word comes back from the store
    if (pend_q) begin
      out_valid_d  = 1'b1;
      pixel_word_d = rd_data_i;
      word_index_d = idx_ext[WORD_IDX_W-1:0];
      last_d       = pend_last_q;
      disp_out_d   = disp_q;
    end

    // New command word
    if (accept) begin
      state_d = ST_IDLE;
      case (opcode_i)
        OP_PIX_CLR, OP_PIX_SET, OP_PIX_INV: begin
          op_d    = op_e'(opcode_i);
          addr_d  = wrap_addr(pix_sum);
          mask_d  = 8'b1 << y_coord_i[2:0];
          state_d = ST_RD;
        end
        OP_FILL, OP_CLEAR: begin
          state_d = ST_IDLE;
        end
        OP_CURSOR: begin
          cursor_d = wrap_addr(cur_sum);
        end
        OP_CHAR: begin
          op_d    = OP_CHAR;
          glyph_d = glyph_columns_i;
          inv_d   = invert_char_i;
          back_d  = step_back_i;
          cnt_d   = '0;
          state_d = ST_RD;
        end
        OP_RAW: begin
          op_d    = OP_RAW;
          raw_d   = raw_byte_i;
          state_d = ST_RD;
        end
        OP_PAGE: begin
          if (disp_q) begin
            page_base_d = WAW'(int'(page_wrap) * WPP);
            k_d         = '0;
            state_d     = ST_PAGE;
          end
        end
        OP_TOGGLE: begin
          disp_d       = !disp_q;
          out_valid_d  = 1'b1;
          pixel_word_d = '0;
          word_index_d = '0;
          last_d       = 1'b1;
          disp_out_d   = !disp_q;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      cnt_q       <= '0;
      disp_q      <= 1'b1;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      cnt_q       <= cnt_d;
      disp_q      <= disp_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    mask_q       <= mask_d;
    glyph_q      <= glyph_d;
    inv_q        <= inv_d;
    back_q       <= back_d;
    raw_q        <= raw_d;
    page_base_q  <= page_base_d;
    pend_idx_q   <= pend_idx_d;
    pend_last_q  <= pend_last_d;
    pixel_word_q <= pixel_word_d;
    word_index_q <= word_index_d;
    last_q       <= last_d;
    disp_out_q   <= disp_out_d;
  end

  assign result_valid_o = out_valid_q;
  assign pixel_word_o   = pixel_word_q;
  assign word_index_o   = word_index_q;
  assign last_word_o    = last_q;
  assign display_on_o   = disp_out_q;

endmodule

// File: rtl/mono_page_frame_buffer_engine_top.sv
// Channel   Direction  Handshake                    Payload
// command   in         start_i high, busy_o low     opcode_i .. page_index_i
// result    out        result_valid_o, one cycle    pixel_word_o, word_index_o,
//                                                   last_word_o, display_on_o
//
// Pixel set/clear/invert and raw byte: one read and one write of a
// 64-bit store word through the single RAM port pair. Character: a read
// and a write per byte, GLYPH_WIDTH bytes. Fill, clear, cursor, toggle and
// unused opcodes: no read or write pass. Page out: one word read per cycle,
// next command taken once the last word of the page is back from the store.
// After reset the store reads as zero at once through per-word valid bits.
// Results stream at one per cycle; the receiver cannot stall them.
module mono_page_frame_buffer_engine_top import mpfb_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [3:0]              opcode_i,
  input  logic [6:0]              x_coord_i,
  input  logic [5:0]              y_coord_i,
  input  logic [2:0]              text_row_i,
  input  logic [4:0]              text_col_i,
  input  logic [GLYPH_BITS-1:0]   glyph_columns_i,
  input  logic                    invert_char_i,
  input  logic                    step_back_i,
  input  logic [7:0]              raw_byte_i,
  input  logic [2:0]              page_index_i,
  output logic                    result_valid_o,
  output logic [PIXEL_WORD_W-1:0] pixel_word_o,
  output logic [WORD_IDX_W-1:0]   word_index_o,
  output logic                    last_word_o,
  output logic                    display_on_o
);

  localparam int NUM_WORDS = PANEL_WIDTH * (PANEL_HEIGHT / 8) / 8;
  localparam int WAW       = $clog2(NUM_WORDS);

  mem_ctl_t                mem_ctl;
  logic [WAW-1:0]          rd_addr;
  logic [WAW-1:0]          wr_addr;
  logic [PIXEL_WORD_W-1:0] wr_data;
  logic [PIXEL_WORD_W-1:0] rd_data;

  mpfb_ctrl #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .text_row_i     (text_row_i),
    .text_col_i     (text_col_i),
    .glyph_columns_i(glyph_columns_i),
    .invert_char_i  (invert_char_i),
    .step_back_i    (step_back_i),
    .raw_byte_i     (raw_byte_i),
    .page_index_i   (page_index_i),
    .mem_ctl_o      (mem_ctl),
    .rd_addr_o      (rd_addr),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_data_i      (rd_data),
    .result_valid_o (result_valid_o),
    .pixel_word_o   (pixel_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o),
    .display_on_o   (display_on_o)
  );

  mpfb_store #(
    .NUM_WORDS(NUM_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

endmodule

// File: rtl/mpfb_chk.sv
`include "mono_page_frame_buffer_engine_top_defines.svh"

// Port-level checks on the frame buffer engine
module mpfb_chk import mpfb_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic [3:0]              opcode_i,
  input logic                    result_valid_o,
  input logic [PIXEL_WORD_W-1:0] pixel_word_o,
  input logic [WORD_IDX_W-1:0]   word_index_o,
  input logic                    last_word_o,
  input logic                    display_on_o
);

  // A toggle word gives its result on the very next cycle
  `MPFB_ASSERT_NEXT(a_toggle_result, clk_i, rst_ni, start_i && !busy_o && (opcode_i == OP_TOGGLE), result_valid_o && last_word_o, "toggle gave no result")

  // Only a toggle can report the display off, and its word is empty
  `MPFB_ASSERT_NOW(a_off_is_toggle, clk_i, rst_ni, result_valid_o && !display_on_o, last_word_o && (word_index_o == '0) && (pixel_word_o == '0), "display off on a page word")

  // Page words stream back to back with rising word index
  `MPFB_ASSERT_NEXT(a_page_stream, clk_i, rst_ni, result_valid_o && !last_word_o, result_valid_o && (word_index_o == 7'($past(word_index_o) + 7'd1)), "page stream broken")

  // A pixel edit holds the command port for its read cycle
  `MPFB_ASSERT_NEXT(a_pixel_busy, clk_i, rst_ni, start_i && !busy_o && (opcode_i == OP_PIX_SET), busy_o, "pixel edit not busy")

endmodule

bind mono_page_frame_buffer_engine_top mpfb_chk u_mpfb_chk (.*);
